// ===== hw/rtl/piecewise_period_next_event_core_defines.svh =====
// Assertion macros shared by the piecewise period next event RTL.
// Depends on nothing; modules that assert include this file by name.
`ifndef PIECEWISE_PERIOD_NEXT_EVENT_CORE_DEFINES_SVH
`define PIECEWISE_PERIOD_NEXT_EVENT_CORE_DEFINES_SVH

// Checks a property at every rising clock edge outside of reset.
`define PPNE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside of reset.
`define PPNE_NEVER(label, cond, msg) \
   `PPNE_ASSERT(label, !(cond), msg)

`endif

// ===== hw/rtl/ppne_pkg.sv =====
// Shared types and constants for the piecewise period next event core.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ppne_pkg;

   localparam int MAX_SEGMENTS = 16;
   localparam int TIME_BITS = 32;
   localparam int IDX_BITS = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_BITS = IDX_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(TIME_BITS);

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [1:0] STS_OK = 2'd0;
   localparam logic [1:0] STS_REJECTED = 2'd1;
   localparam logic [1:0] STS_FULL = 2'd2;
   localparam logic [1:0] STS_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [TIME_BITS-1:0] time_value;
      logic [TIME_BITS-1:0] period;
   } req_payload_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] next_time;
      logic [1:0] status;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_BASE,
      SRC_RESULT
   } rsp_src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_CHK,
      ST_QRY_RD,
      ST_QRY_CHK,
      ST_DIV,
      ST_OFS,
      ST_FIN
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic rd_last;
      logic clear_tbl;
      logic write_seg;
      logic advance;
      logic seg_load;
      logic div_step;
      logic ofs_calc;
      logic emit;
      rsp_src_type rsp_src;
      logic [1:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic table_full;
      logic add_bad;
      logic can_advance;
      logic before_base;
      logic div_last;
   } dp_flags_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ppne_ctrl.sv =====
// Controller state machine of the piecewise period next event core.
// Depends on ppne_pkg; drives the datapath through command and status structs.
`default_nettype none

module ppne_ctrl
   import ppne_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [1:0] action,
   input wire dp_flags_type flags,
   output dp_cmd_type cmd,
   output logic busy
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rsp_src = SRC_ZERO;
      cmd.rsp_status = STS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.rd_last = (action == ACT_ADD);
            if (start) begin
               cmd.capture = 1'b1;
               unique case (action)
                  ACT_CLEAR: begin
                     cmd.clear_tbl = 1'b1;
                     cmd.emit = 1'b1;
                  end
                  ACT_ADD: begin
                     state_in = ST_ADD_CHK;
                  end
                  ACT_QUERY: begin
                     if (flags.count_zero) begin
                        cmd.emit = 1'b1;
                        cmd.rsp_status = STS_EMPTY;
                     end else begin
                        state_in = ST_QRY_CHK;
                     end
                  end
                  default: begin
                     cmd.emit = 1'b1;
                  end
               endcase
            end
         end
         ST_ADD_CHK: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
            priority if (flags.add_bad) begin
               cmd.rsp_status = STS_REJECTED;
            end else if (flags.table_full) begin
               cmd.rsp_status = STS_FULL;
            end else begin
               cmd.write_seg = 1'b1;
            end
         end
         ST_QRY_RD: begin
            state_in = ST_QRY_CHK;
         end
         ST_QRY_CHK: begin
            priority if (flags.can_advance) begin
               cmd.advance = 1'b1;
               state_in = ST_QRY_RD;
            end else if (flags.before_base) begin
               cmd.emit = 1'b1;
               cmd.rsp_src = SRC_BASE;
               state_in = ST_IDLE;
            end else begin
               cmd.seg_load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (flags.div_last) begin
               state_in = ST_OFS;
            end
         end
         ST_OFS: begin
            cmd.ofs_calc = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.emit = 1'b1;
            cmd.rsp_src = SRC_RESULT;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/ppne_dp.sv =====
// Datapath of the piecewise period next event core: segment memories, pointer,
// remainder divider and result register. Depends on ppne_pkg and the defines header.
`default_nettype none

`include "piecewise_period_next_event_core_defines.svh"

module ppne_dp
   import ppne_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire req_payload_type req_payload,
   input wire dp_cmd_type cmd,
   output dp_flags_type flags,
   output logic rsp_valid,
   output rsp_payload_type rsp_payload
);

   logic [TIME_BITS-1:0] seg_start_ff [MAX_SEGMENTS];
   logic [TIME_BITS-1:0] seg_period_ff [MAX_SEGMENTS];
   logic [TIME_BITS-1:0] rd_start_a_ff;
   logic [TIME_BITS-1:0] rd_period_a_ff;
   logic [TIME_BITS-1:0] rd_start_b_ff;

   req_payload_type req_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [IDX_BITS-1:0] cur_ff;
   logic [TIME_BITS-1:0] base_ff;
   logic [TIME_BITS-1:0] period_ff;
   logic [TIME_BITS-1:0] limit_ff;
   logic [TIME_BITS-1:0] diff_ff;
   logic [TIME_BITS-1:0] shift_ff;
   logic [TIME_BITS-1:0] rem_ff;
   logic [TIME_BITS:0] offset_ff;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   logic rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic [CNT_BITS-1:0] count_m1;
   logic [CNT_BITS-1:0] cur_plus1;
   logic [IDX_BITS-1:0] addr_a;
   logic [IDX_BITS-1:0] addr_b;
   logic has_next;
   logic [TIME_BITS:0] shifted;
   logic [TIME_BITS:0] trial;
   logic [TIME_BITS+1:0] sum;
   logic [TIME_BITS-1:0] sat;
   logic [TIME_BITS-1:0] result;
   rsp_payload_type rsp_in;

   assign count_m1 = count_ff - CNT_BITS'(1);
   assign cur_plus1 = CNT_BITS'(cur_ff) + CNT_BITS'(1);
   assign addr_a = cmd.rd_last ? count_m1[IDX_BITS-1:0] : cur_ff;
   assign addr_b = cur_plus1[IDX_BITS-1:0];
   assign has_next = (cur_plus1 < count_ff);

   always_ff @(posedge clock) begin
      if (cmd.write_seg) begin
         seg_start_ff[count_ff[IDX_BITS-1:0]] <= req_ff.time_value;
         seg_period_ff[count_ff[IDX_BITS-1:0]] <= req_ff.period;
      end
      rd_start_a_ff <= seg_start_ff[addr_a];
      rd_period_a_ff <= seg_period_ff[addr_a];
      rd_start_b_ff <= seg_start_ff[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cur_ff <= '0;
      end else if (cmd.clear_tbl) begin
         count_ff <= '0;
         cur_ff <= '0;
      end else begin
         if (cmd.write_seg) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end
         if (cmd.advance) begin
            cur_ff <= addr_b;
         end
      end
   end

   assign shifted = {rem_ff, shift_ff[TIME_BITS-1]};
   assign trial = shifted - {1'b0, period_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.seg_load) begin
         base_ff <= rd_start_a_ff;
         period_ff <= rd_period_a_ff;
         limit_ff <= has_next ? rd_start_b_ff : TIME_MAX;
         diff_ff <= req_ff.time_value - rd_start_a_ff;
         shift_ff <= req_ff.time_value - rd_start_a_ff;
         rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= (shifted >= {1'b0, period_ff}) ? trial[TIME_BITS-1:0]
                                                  : shifted[TIME_BITS-1:0];
         shift_ff <= {shift_ff[TIME_BITS-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + DIV_CNT_BITS'(1);
      end
      if (cmd.ofs_calc) begin
         offset_ff <= {1'b0, diff_ff} - {1'b0, rem_ff} + {1'b0, period_ff};
      end
   end

   assign sum = (TIME_BITS+2)'(base_ff) + (TIME_BITS+2)'(offset_ff);
   assign sat = (sum > (TIME_BITS+2)'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
   assign result = (sat > limit_ff) ? limit_ff : sat;

   always_comb begin
      rsp_in.status = cmd.rsp_status;
      unique case (cmd.rsp_src)
         SRC_ZERO: rsp_in.next_time = '0;
         SRC_BASE: rsp_in.next_time = rd_start_a_ff;
         SRC_RESULT: rsp_in.next_time = result;
         default: rsp_in.next_time = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign flags.count_zero = (count_ff == '0);
   assign flags.table_full = (count_ff == CNT_BITS'(MAX_SEGMENTS));
   assign flags.add_bad = (req_ff.period == '0) ||
                          ((count_ff != '0) && (rd_start_a_ff >= req_ff.time_value));
   assign flags.can_advance = has_next && (req_ff.time_value >= rd_start_b_ff);
   assign flags.before_base = (req_ff.time_value < rd_start_a_ff);
   assign flags.div_last = (div_cnt_ff == DIV_CNT_BITS'(TIME_BITS - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `PPNE_NEVER(a_count_bound, count_ff > CNT_BITS'(MAX_SEGMENTS), "segment count above table size")
   `PPNE_ASSERT(a_cur_below_count, (count_ff == '0) || (CNT_BITS'(cur_ff) < count_ff), "segment pointer past table end")
   `PPNE_NEVER(a_write_when_full, cmd.write_seg && flags.table_full, "segment written into full table")
   `PPNE_ASSERT(a_zero_time_on_error, rsp_valid_ff && (rsp_ff.status != STS_OK) |-> (rsp_ff.next_time == '0), "error result carries a time")

endmodule

`default_nettype wire

// ===== hw/rtl/piecewise_period_next_event_core.sv =====
// Top level of the piecewise period next event core.
// Depends on ppne_pkg, ppne_ctrl and ppne_dp.
`default_nettype none

// A transfer is taken when start is high and busy is low; each result appears for exactly one
// cycle with rsp_valid and cannot be held off. Clear, an unknown action and a query on an empty
// table are answered straight from idle, and the next transfer may follow at once. An add first
// does one registered memory read of the last start, then the check and write. A query moves the
// pointer, by a read and a check, past each segment whose next start is at or before the time;
// when the time lies at or after the segment start, a remainder divider that settles one bit per
// cycle runs over all TIME_BITS bits, then the offset and clamp.

module piecewise_period_next_event_core
   import ppne_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire req_payload_type req_payload,
   output logic rsp_valid,
   output rsp_payload_type rsp_payload
);

   dp_cmd_type cmd;
   dp_flags_type flags;

   ppne_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .action(req_payload.action),
      .flags(flags),
      .cmd(cmd),
      .busy(busy)
   );

   ppne_dp u_dp (
      .clock(clock),
      .reset(reset),
      .req_payload(req_payload),
      .cmd(cmd),
      .flags(flags),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire
